@@ hw/rtl/ddiff_pkg.sv @@
// ----------------------------------------------------------------------------
// ddiff_pkg
// Shared types, constants and calendar functions for the date difference block.
// ----------------------------------------------------------------------------
package ddiff_pkg;

   // Field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int COUNT_W  = 22;
   localparam int STATUS_W = 2;

   // Calendar limits
   localparam logic [YEAR_W-1:0]  YEAR_LIMIT   = YEAR_W'(9999);
   localparam logic [MONTH_W-1:0] MONTHS       = MONTH_W'(12);
   localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

   // Reciprocal of 25 for the century test, exact for 12-bit operands
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_25    = ((2 ** RECIP_SHIFT) + 24) / 25;

   // Month codes that share a length
   localparam logic [MONTH_W-1:0] FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] APR = MONTH_W'(4);
   localparam logic [MONTH_W-1:0] JUN = MONTH_W'(6);
   localparam logic [MONTH_W-1:0] SEP = MONTH_W'(9);
   localparam logic [MONTH_W-1:0] NOV = MONTH_W'(11);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ORDER   = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAP_S,
      ST_CHK_S,
      ST_CHK_E,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef enum logic {
      LEAP_WALK,
      LEAP_END
   } leap_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic         load;
      leap_sel_type leap_sel;
      logic         chk_start;
      logic         status_wr;
      status_type   status_code;
      logic         step;
      logic         out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic start_ok;
      logic end_ok;
      logic order_bad;
      logic at_end;
   } stat_type;

   // Leap year by the 4/100/400 rule, two constant multiplies
   function automatic logic leap_year(input logic [YEAR_W-1:0] y);
      logic [YEAR_W-3:0]               quarter;
      logic [YEAR_W-3+RECIP_SHIFT-1:0] prod;
      logic [YEAR_W-3:0]               cent;
      logic [YEAR_W-3:0]               back;
      logic                            by100;
      logic                            by400;
      quarter = y[YEAR_W-1:2];
      prod    = (YEAR_W-3+RECIP_SHIFT)'(quarter) * (YEAR_W-3+RECIP_SHIFT)'(RECIP_25);
      cent    = (YEAR_W-2)'(prod >> RECIP_SHIFT);
      back    = (YEAR_W-2)'(cent * (YEAR_W-2)'(25));
      by100   = (y[1:0] == 2'b00) && (back == quarter);
      by400   = by100 && (cent[1:0] == 2'b00);
      return ((y[1:0] == 2'b00) && !by100) || by400;
   endfunction

   // Length of a month, months outside 1..12 fall to 31 and are caught elsewhere
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      len = DAY_W'(31);
      case (m) inside
         FEB:                len = leap ? DAY_W'(29) : DAY_W'(28);
         APR, JUN, SEP, NOV: len = DAY_W'(30);
         default:            len = DAY_W'(31);
      endcase
      return len;
   endfunction

   function automatic logic date_ok(input logic [YEAR_W-1:0] y,
                                    input logic [MONTH_W-1:0] m,
                                    input logic [DAY_W-1:0] d,
                                    input logic leap);
      return (y != '0) && (y <= YEAR_LIMIT) && (m != '0) && (m <= MONTHS) &&
             (d != '0) && (d <= month_days(m, leap));
   endfunction

endpackage

@@ hw/rtl/ddiff_dp.sv @@
// ----------------------------------------------------------------------------
// ddiff_dp
// Datapath: date registers, leap unit, validity and order checks, day walker
// and the result register.
// ----------------------------------------------------------------------------
module ddiff_dp (
   input  logic                              clock,
   input  ddiff_pkg::cmd_type                cmd,
   output ddiff_pkg::stat_type               stat,
   input  logic [ddiff_pkg::YEAR_W-1:0]      start_year,
   input  logic [ddiff_pkg::MONTH_W-1:0]     start_month,
   input  logic [ddiff_pkg::DAY_W-1:0]       start_day,
   input  logic [ddiff_pkg::YEAR_W-1:0]      end_year,
   input  logic [ddiff_pkg::MONTH_W-1:0]     end_month,
   input  logic [ddiff_pkg::DAY_W-1:0]       end_day,
   output logic [ddiff_pkg::COUNT_W-1:0]     day_count,
   output ddiff_pkg::status_type             status
);

   logic [ddiff_pkg::YEAR_W-1:0]  walk_year_ff,  walk_year_in;
   logic [ddiff_pkg::MONTH_W-1:0] walk_month_ff, walk_month_in;
   logic [ddiff_pkg::DAY_W-1:0]   walk_day_ff,   walk_day_in;
   logic [ddiff_pkg::COUNT_W-1:0] elapsed_ff,    elapsed_in;
   logic [ddiff_pkg::YEAR_W-1:0]  end_year_ff;
   logic [ddiff_pkg::MONTH_W-1:0] end_month_ff;
   logic [ddiff_pkg::DAY_W-1:0]   end_day_ff;
   logic                          leap_ff,       leap_in;
   logic                          start_ok_ff,   start_ok_in;
   ddiff_pkg::status_type         status_ff,     status_in;
   logic [ddiff_pkg::COUNT_W-1:0] rsp_count_ff;
   ddiff_pkg::status_type         rsp_status_ff;
   logic [ddiff_pkg::YEAR_W-1:0]  leap_year_sel;
   logic                          month_end;
   logic                          year_end;

   // Pick the year for the leap unit
   always_comb begin
      unique case (cmd.leap_sel)
         ddiff_pkg::LEAP_END:  leap_year_sel = end_year_ff;
         ddiff_pkg::LEAP_WALK: leap_year_sel = walk_year_ff;
         default:              leap_year_sel = walk_year_ff;
      endcase
      leap_in = ddiff_pkg::leap_year(leap_year_sel);
   end

   // Check dates and order
   always_comb begin
      start_ok_in = cmd.chk_start ?
                    ddiff_pkg::date_ok(walk_year_ff, walk_month_ff, walk_day_ff, leap_ff) :
                    start_ok_ff;
      stat.start_ok  = start_ok_ff;
      stat.end_ok    = ddiff_pkg::date_ok(end_year_ff, end_month_ff, end_day_ff, leap_ff);
      stat.order_bad = {walk_year_ff, walk_month_ff, walk_day_ff} >
                       {end_year_ff, end_month_ff, end_day_ff};
      stat.at_end    = (walk_year_ff == end_year_ff) && (walk_month_ff == end_month_ff) &&
                       (walk_day_ff == end_day_ff);
   end

   // Load the start date, or advance the walk date by one day and count it
   always_comb begin
      month_end     = walk_day_ff == ddiff_pkg::month_days(walk_month_ff, leap_ff);
      year_end      = walk_month_ff == ddiff_pkg::MONTHS;
      walk_year_in  = walk_year_ff;
      walk_month_in = walk_month_ff;
      walk_day_in   = walk_day_ff;
      elapsed_in    = elapsed_ff;
      status_in     = cmd.status_wr ? cmd.status_code : status_ff;
      if (cmd.load) begin
         walk_year_in  = start_year;
         walk_month_in = start_month;
         walk_day_in   = start_day;
         elapsed_in    = '0;
      end else if (cmd.step) begin
         if (month_end) begin
            walk_day_in = ddiff_pkg::DAY_W'(1);
            if (year_end) begin
               walk_month_in = ddiff_pkg::MONTH_W'(1);
               walk_year_in  = walk_year_ff + ddiff_pkg::YEAR_W'(1);
            end else begin
               walk_month_in = walk_month_ff + ddiff_pkg::MONTH_W'(1);
            end
         end else begin
            walk_day_in = walk_day_ff + ddiff_pkg::DAY_W'(1);
         end
         if (elapsed_ff != ddiff_pkg::COUNT_MAX) begin
            elapsed_in = elapsed_ff + ddiff_pkg::COUNT_W'(1);
         end
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      walk_year_ff  <= walk_year_in;
      walk_month_ff <= walk_month_in;
      walk_day_ff   <= walk_day_in;
      elapsed_ff    <= elapsed_in;
      leap_ff       <= leap_in;
      start_ok_ff   <= start_ok_in;
      status_ff     <= status_in;
      if (cmd.load) begin
         end_year_ff  <= end_year;
         end_month_ff <= end_month;
         end_day_ff   <= end_day;
      end
      if (cmd.out_load) begin
         rsp_count_ff  <= elapsed_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign day_count = rsp_count_ff;
   assign status    = rsp_status_ff;

endmodule

@@ hw/rtl/ddiff_ctrl.sv @@
// ----------------------------------------------------------------------------
// ddiff_ctrl
// Controller: sequences load, validity checks, the day walk and the result
// handoff; owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
module ddiff_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  ddiff_pkg::stat_type  stat,
   output ddiff_pkg::cmd_type   cmd
);

   ddiff_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ddiff_pkg::ST_IDLE:   if (req_tvalid) state_in = ddiff_pkg::ST_LEAP_S;
         ddiff_pkg::ST_LEAP_S: state_in = ddiff_pkg::ST_CHK_S;
         ddiff_pkg::ST_CHK_S:  state_in = ddiff_pkg::ST_CHK_E;
         ddiff_pkg::ST_CHK_E: begin
            if (!stat.start_ok || !stat.end_ok || stat.order_bad) begin
               state_in = ddiff_pkg::ST_DONE;
            end else begin
               state_in = ddiff_pkg::ST_WALK;
            end
         end
         ddiff_pkg::ST_WALK:   if (stat.at_end) state_in = ddiff_pkg::ST_DONE;
         ddiff_pkg::ST_DONE:   if (out_free) state_in = ddiff_pkg::ST_IDLE;
         default:              state_in = ddiff_pkg::ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd             = '0;
      cmd.leap_sel    = ddiff_pkg::LEAP_WALK;
      cmd.status_code = ddiff_pkg::STATUS_OK;
      req_tready      = 1'b0;
      unique case (state_ff)
         ddiff_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ddiff_pkg::ST_LEAP_S: cmd.leap_sel = ddiff_pkg::LEAP_WALK;
         ddiff_pkg::ST_CHK_S: begin
            cmd.leap_sel  = ddiff_pkg::LEAP_END;
            cmd.chk_start = 1'b1;
         end
         ddiff_pkg::ST_CHK_E: begin
            cmd.status_wr = 1'b1;
            if (!stat.start_ok || !stat.end_ok) begin
               cmd.status_code = ddiff_pkg::STATUS_INVALID;
            end else if (stat.order_bad) begin
               cmd.status_code = ddiff_pkg::STATUS_ORDER;
            end else begin
               cmd.status_code = ddiff_pkg::STATUS_OK;
            end
         end
         ddiff_pkg::ST_WALK:   cmd.step     = !stat.at_end;
         ddiff_pkg::ST_DONE:   cmd.out_load = out_free;
         default:              cmd          = '0;
      endcase
   end

   // Track the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddiff_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ hw/rtl/date_difference_days.sv @@
// ----------------------------------------------------------------------------
// date_difference_days
// Days from a start Gregorian date to an end date, counted by a day walker.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one transaction with both dates; rsp channel returns
//   one transaction with the day count in tdata and the status in tuser
//   (0 ok, 1 start after end, 2 invalid date; count is zero unless ok).
//   One transaction is in work at a time: req_tready is high only when the
//   block is idle.
// Sequence:
//   on acceptance both dates are loaded; the controller then looks up the
//   start year's leap flag, checks the start date, then the end date and order.
//   A valid transaction then walks to the end date and loads the result; an
//   error skips the walk. The walker steps one calendar day per cycle through
//   a single incrementer.
// Reset:
//   reset clears the controller to idle and drops rsp_tvalid.
// Stall:
//   a finished result sits in the output register until rsp_tready; while it
//   waits, the next transaction is accepted and worked on, and its result
//   holds in the datapath until the output register frees.
// ----------------------------------------------------------------------------
module date_difference_days (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // start_year[13:0], start_month[17:14], start_day[22:18],
   // end_year[36:23], end_month[40:37], end_day[45:41], zero fill [47:46]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // day_count[21:0], zero fill [23:22]
   output logic [23:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser
);

   ddiff_pkg::cmd_type                cmd;
   ddiff_pkg::stat_type               stat;
   logic [ddiff_pkg::COUNT_W-1:0]     day_count;
   ddiff_pkg::status_type             status;

   ddiff_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ddiff_dp u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .stat        (stat),
      .start_year  (req_tdata[13:0]),
      .start_month (req_tdata[17:14]),
      .start_day   (req_tdata[22:18]),
      .end_year    (req_tdata[36:23]),
      .end_month   (req_tdata[40:37]),
      .end_day     (req_tdata[45:41]),
      .day_count   (day_count),
      .status      (status)
   );

   // Pack the result transaction
   assign rsp_tdata = {2'b00, day_count};
   assign rsp_tuser = status;

endmodule

@@ hw/rtl/ddiff_check.sv @@
// ----------------------------------------------------------------------------
// ddiff_check
// Port-level checks for date_difference_days, bound to the top level.
// ----------------------------------------------------------------------------
module ddiff_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A waiting result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // An error result carries no count
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ddiff_pkg::STATUS_OK) |-> (rsp_tdata == '0))
      else $error("nonzero day count on error status");

   // Status never goes past the last defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= ddiff_pkg::STATUS_INVALID))
      else $error("unused status code");

   // Accepting a transaction closes the request side while it is in work
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // No result comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind date_difference_days ddiff_check u_ddiff_check (.*);

@@ sim/ddiff_span_checker.sv @@
// ----------------------------------------------------------------------------
// ddiff_span_checker
// Watches both streams of the date difference block, works out the day count
// and status for every accepted request, and compares each response against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ddiff_span_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int unsigned fail_count,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // One calendar date, year in the low bits as on the request bus
   typedef struct packed {
      logic [ddiff_pkg::DAY_W-1:0]   day;
      logic [ddiff_pkg::MONTH_W-1:0] month;
      logic [ddiff_pkg::YEAR_W-1:0]  year;
   } cal_date_type;

   typedef struct {
      logic [ddiff_pkg::COUNT_W-1:0] days;
      ddiff_pkg::status_type         status;
   } span_result_type;

   span_result_type span_q[$];
   int unsigned     faults  = 0;
   int unsigned     q_level = 0;

   assign fail_count  = faults;
   assign outstanding = q_level;

   function automatic bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned month_length(int unsigned y,
                                                logic [ddiff_pkg::MONTH_W-1:0] m);
      case (m) inside
         ddiff_pkg::FEB: return is_leap(y) ? 29 : 28;
         ddiff_pkg::APR, ddiff_pkg::JUN, ddiff_pkg::SEP, ddiff_pkg::NOV: return 30;
         default:        return 31;
      endcase
   endfunction

   function automatic bit date_valid(cal_date_type dt);
      if (dt.year == 0 || dt.year > ddiff_pkg::YEAR_LIMIT) return 1'b0;
      if (dt.month == 0 || dt.month > ddiff_pkg::MONTHS) return 1'b0;
      if (dt.day == 0 || dt.day > month_length(dt.year, dt.month)) return 1'b0;
      return 1'b1;
   endfunction

   // Days since 1 January of year 1
   function automatic int unsigned day_index(cal_date_type dt);
      int unsigned p;
      int unsigned n;
      p = dt.year - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      for (int unsigned mo = 1; mo < dt.month; mo++)
         n += month_length(dt.year, ddiff_pkg::MONTH_W'(mo));
      return n + dt.day - 1;
   endfunction

   // Validity first, then order, then the saturated count
   function automatic span_result_type predict_span(cal_date_type from_date,
                                                    cal_date_type to_date);
      span_result_type res;
      int unsigned     from_idx;
      int unsigned     to_idx;
      res.days   = '0;
      res.status = ddiff_pkg::STATUS_OK;
      if (!date_valid(from_date) || !date_valid(to_date)) begin
         res.status = ddiff_pkg::STATUS_INVALID;
      end else begin
         from_idx = day_index(from_date);
         to_idx   = day_index(to_date);
         if (from_idx > to_idx)
            res.status = ddiff_pkg::STATUS_ORDER;
         else if (to_idx - from_idx > ddiff_pkg::COUNT_MAX)
            res.days = ddiff_pkg::COUNT_MAX;
         else
            res.days = ddiff_pkg::COUNT_W'(to_idx - from_idx);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      span_result_type pred;
      span_result_type want;
      cal_date_type    from_date;
      cal_date_type    to_date;
      if (reset) begin
         span_q.delete();
      end else begin
         // Predict every accepted request transaction
         if (req_tvalid && req_tready) begin
            from_date = req_tdata[22:0];
            to_date   = req_tdata[45:23];
            pred      = predict_span(from_date, to_date);
            span_q.push_back(pred);
         end
         // Compare every accepted response transaction
         if (rsp_tvalid && rsp_tready) begin
            if (span_q.size() == 0) begin
               $error("response with no request outstanding: day_count %0d status %0d",
                      rsp_tdata[21:0], rsp_tuser);
               faults++;
            end else begin
               want = span_q.pop_front();
               if (rsp_tdata[21:0] !== want.days) begin
                  $error("day_count mismatch: expected %0d, actual %0d",
                         want.days, rsp_tdata[21:0]);
                  faults++;
               end
               if (rsp_tdata[23:22] !== 2'b00) begin
                  $error("tdata fill mismatch: expected 0, actual %0d", rsp_tdata[23:22]);
                  faults++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_tuser);
                  faults++;
               end
            end
         end
      end
      q_level = span_q.size();
   end

endmodule

@@ sim/tb_date_difference_days.sv @@
// ----------------------------------------------------------------------------
// tb_date_difference_days
// Drives date pairs into the day walker: calendar corner cases first, then
// random pairs with short spans plus corrupted and reversed dates, with random
// idle bursts on both streams and one long response hold-off. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_date_difference_days;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_PAIRS = 75;
   localparam int unsigned HOLD_CYCLES  = 4000;
   localparam int unsigned CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      logic [ddiff_pkg::DAY_W-1:0]   day;
      logic [ddiff_pkg::MONTH_W-1:0] month;
      logic [ddiff_pkg::YEAR_W-1:0]  year;
   } cal_date_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned cycle_count  = 0;
   bit          quiet        = 1'b1;
   bit          hold_off_req = 1'b0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   date_difference_days i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ddiff_span_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic cal_date_type mk_date(int unsigned y, int unsigned m, int unsigned d);
      cal_date_type dt;
      dt.year  = ddiff_pkg::YEAR_W'(y);
      dt.month = ddiff_pkg::MONTH_W'(m);
      dt.day   = ddiff_pkg::DAY_W'(d);
      return dt;
   endfunction

   // Mostly days 1..28; the odd 29..31 may land on an invalid date
   function automatic cal_date_type pick_date(int unsigned y_lo, int unsigned y_hi);
      cal_date_type dt;
      dt.year  = ddiff_pkg::YEAR_W'($urandom_range(y_hi, y_lo));
      dt.month = ddiff_pkg::MONTH_W'($urandom_range(12, 1));
      if ($urandom_range(0, 7) == 0)
         dt.day = ddiff_pkg::DAY_W'($urandom_range(31, 29));
      else
         dt.day = ddiff_pkg::DAY_W'($urandom_range(28, 1));
      return dt;
   endfunction

   // Offer one request transaction, hold until accepted, then maybe idle
   task automatic send_pair(input cal_date_type from_date, input cal_date_type to_date);
      req_tdata  <= {2'b00, to_date, from_date};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Ordered pair with a short span; a few reversed or corrupted
   task automatic send_random_pair();
      cal_date_type a;
      cal_date_type b;
      cal_date_type t;
      int unsigned  kind;
      kind = $urandom_range(0, 19);
      a = pick_date(1, 9996);
      b = pick_date(a.year, a.year);
      if (kind < 8)
         b.month = a.month;
      else if (kind < 11)
         b.year = a.year + ddiff_pkg::YEAR_W'($urandom_range(3, 1));
      if ({b.year, b.month, b.day} < {a.year, a.month, a.day}) begin
         t = a;
         a = b;
         b = t;
      end
      case (kind)
         17: begin
            t = a;
            a = b;
            b = t;
         end
         18: begin
            if ($urandom_range(0, 1)) begin
               a.month = ddiff_pkg::MONTH_W'($urandom);
               a.day   = ddiff_pkg::DAY_W'($urandom);
            end else begin
               b.month = ddiff_pkg::MONTH_W'($urandom);
               b.day   = ddiff_pkg::DAY_W'($urandom);
            end
         end
         19: begin
            t.year = ($urandom_range(0, 3) == 0) ? '0 :
                     ddiff_pkg::YEAR_W'($urandom_range(16383, 10000));
            if ($urandom_range(0, 1))
               a.year = t.year;
            else
               b.year = t.year;
         end
         default: ;
      endcase
      send_pair(a, b);
   endtask

   // Receiver: random stall bursts, one long hold-off on request
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Equal dates, range extremes and reversed order
      send_pair(mk_date(1, 1, 1), mk_date(1, 1, 1));
      send_pair(mk_date(9999, 12, 31), mk_date(9999, 12, 31));
      send_pair(mk_date(9999, 12, 31), mk_date(1, 1, 1));
      send_pair(mk_date(1, 1, 1), mk_date(3, 12, 31));
      send_pair(mk_date(9998, 12, 31), mk_date(9999, 12, 31));
      // Leap rule around February
      send_pair(mk_date(1900, 2, 28), mk_date(1900, 3, 1));
      send_pair(mk_date(2000, 2, 28), mk_date(2000, 3, 1));
      send_pair(mk_date(2100, 2, 28), mk_date(2100, 3, 1));
      send_pair(mk_date(2400, 2, 29), mk_date(2400, 3, 1));
      send_pair(mk_date(2004, 2, 29), mk_date(2005, 2, 28));
      send_pair(mk_date(1900, 2, 29), mk_date(1900, 3, 1));
      send_pair(mk_date(2001, 2, 29), mk_date(2001, 3, 1));
      // Day beyond a short month, zero and out of range fields
      send_pair(mk_date(2023, 4, 31), mk_date(2023, 5, 1));
      send_pair(mk_date(2023, 10, 1), mk_date(2023, 11, 31));
      send_pair(mk_date(2023, 5, 0), mk_date(2023, 6, 1));
      send_pair(mk_date(2023, 0, 5), mk_date(2023, 6, 1));
      send_pair(mk_date(2023, 1, 5), mk_date(2023, 13, 1));
      send_pair(mk_date(2023, 15, 5), mk_date(2024, 1, 1));
      send_pair(mk_date(0, 1, 1), mk_date(1, 1, 1));
      send_pair(mk_date(1, 1, 1), mk_date(10000, 1, 1));
      send_pair(mk_date(16383, 15, 31), mk_date(16383, 15, 31));
      // Month and year rollover, one day backwards, one long walk
      send_pair(mk_date(2024, 12, 31), mk_date(2025, 1, 1));
      send_pair(mk_date(2024, 1, 31), mk_date(2024, 2, 1));
      send_pair(mk_date(2024, 3, 2), mk_date(2024, 3, 1));
      send_pair(mk_date(1890, 6, 15), mk_date(2001, 3, 1));

      // Random pairs; hold off the receiver once, finish without idling
      quiet = 1'b0;
      for (int unsigned i = 0; i < RANDOM_PAIRS; i++) begin
         if (i == 30) hold_off_req = 1'b1;
         if (i == RANDOM_PAIRS - 20) quiet = 1'b1;
         send_random_pair();
      end
      req_tvalid <= 1'b0;

      // Drain, then let the pipeline settle
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/ddiff_pkg.sv
hw/rtl/ddiff_dp.sv
hw/rtl/ddiff_ctrl.sv
hw/rtl/date_difference_days.sv
hw/rtl/ddiff_check.sv
sim/ddiff_span_checker.sv
sim/tb_date_difference_days.sv
